@@ src/rtig_pkg.sv @@
// Shared types and constants for the RGB to gray post-processing block.
// No dependencies; imported by every module of the block.
package rtig_pkg;

  // BT.601 weights with 16 fractional bits (sum to 65536)
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_B = 16'd7471;

  localparam logic [31:0] NOISE_SEED = 32'h6D2B_79F5;
  localparam logic [23:0] UNIT_MAX   = 24'hFF_FFFF;
  localparam logic [55:0] UNIT_HALF  = 56'd8388607;
  localparam logic [31:0] GRAY_MAX_Q24 = 32'hFF00_0000;
  localparam logic [32:0] HALF_Q24     = 33'h0_0080_0000;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_HOT = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray_value;
    logic       frame_end_out;
  } gray_t;

  typedef struct packed {
    logic [15:0] display_gain;
    logic [12:0] display_offset;
    logic        noise_enable;
    logic [15:0] noise_sigma;
    logic        white_hot;
  } cfg_t;

  // One classified pixel as handed from front to back
  typedef struct packed {
    logic [23:0] luma;       // Q.16 luma
    logic [23:0] noise_mag;  // |2u - UNIT_MAX|
    logic        neg;        // noise sign
    logic        noise_on;
    logic        frame_end;
  } entry_t;

endpackage

@@ src/rtig_front.sv @@
// Front end: accepts pixels, forms luma and draws the noise sample.
// Depends on rtig_pkg.
module rtig_front
  import rtig_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  logic [31:0] noise_state;
  logic [31:0] noise_state_next;
  logic [31:0] x1;
  logic [31:0] x2;
  logic        noise_on;

  always_comb begin
    x1 = noise_state ^ (noise_state << 13);
    x2 = x1 ^ (x1 >> 17);
    noise_state_next = x2 ^ (x2 << 5);
  end

  assign noise_on    = cfg.noise_enable && (cfg.noise_sigma != 16'd0);
  assign pixel_stall = q_full;
  assign q_push      = pixel_valid && !q_full;

  always_comb begin
    q_entry.luma = 24'(COEF_R) * 24'(pixel.red) + 24'(COEF_G) * 24'(pixel.green)
                 + 24'(COEF_B) * 24'(pixel.blue);
    // u >= 2^23 gives a non-negative offset; magnitude is odd either way
    q_entry.noise_mag = {(noise_state_next[23] ? noise_state_next[22:0]
                                               : ~noise_state_next[22:0]), 1'b1};
    q_entry.neg       = !noise_state_next[23];
    q_entry.noise_on  = noise_on;
    q_entry.frame_end = pixel.frame_end_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_state <= NOISE_SEED;
    end else if (q_push && noise_on) begin
      noise_state <= noise_state_next;
    end
  end

endmodule

@@ src/rtig_queue.sv @@
// Short register queue that decouples the front end from the back end.
// Depends on rtig_pkg.
module rtig_queue
  import rtig_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   avail,
  output entry_t head
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rtig_back.sv @@
// Back end: gain, offset, noise scaling, clamp, polarity and rounding.
// Six-stage pipeline with a global hold on output stall. Depends on rtig_pkg.
module rtig_back
  import rtig_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_avail,
  output logic   q_pop,
  input  entry_t q_head,
  output logic   gray_valid,
  input  logic   gray_stall,
  output gray_t  gray
);

  logic en;

  // stage valids
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic [39:0] s1_prod;
  logic [23:0] s1_dist;
  logic        s1_neg, s1_on, s1_fe;
  // stage 2
  logic [39:0]        s2_p;
  logic signed [42:0] s2_base;
  logic               s2_neg, s2_on, s2_fe;
  // stage 3
  logic [31:0]        s3_q0;
  logic [32:0]        s3_r;
  logic signed [42:0] s3_base;
  logic               s3_neg, s3_on, s3_fe;
  // stage 4
  logic [31:0]        s4_q;
  logic signed [42:0] s4_base;
  logic               s4_neg, s4_on, s4_fe;
  // stage 5
  logic [31:0] s5_level;
  logic        s5_fe;

  logic [55:0]        num;
  logic [8:0]         q1;
  logic [24:0]        r1;
  logic signed [42:0] noise;
  logic signed [42:0] total;
  logic [31:0]        clamped;
  logic [32:0]        rounded;

  assign en    = !gray_valid || !gray_stall;
  assign q_pop = q_avail && en;

  always_comb begin
    num     = {s2_p, 16'd0} + UNIT_HALF;
    q1      = s3_r[32:24];
    r1      = 25'(s3_r[23:0]) + 25'(q1);
    noise   = s4_on ? (s4_neg ? -$signed({11'd0, s4_q}) : $signed({11'd0, s4_q})) : '0;
    total   = s4_base + noise;
    if (total[42]) begin
      clamped = '0;
    end else if (total > $signed({11'd0, GRAY_MAX_Q24})) begin
      clamped = GRAY_MAX_Q24;
    end else begin
      clamped = total[31:0];
    end
    rounded = 33'(s5_level) + HALF_Q24;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      gray_valid <= 1'b0;
    end else if (en) begin
      v1 <= q_avail;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      gray_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // luma times gain: Q.24
      s1_prod <= 40'(q_head.luma) * 40'(cfg.display_gain);
      s1_dist <= q_head.noise_mag;
      s1_neg  <= q_head.neg;
      s1_on   <= q_head.noise_on;
      s1_fe   <= q_head.frame_end;

      s2_p    <= 40'(s1_dist) * 40'(cfg.noise_sigma);
      s2_base <= $signed({3'd0, s1_prod})
               + $signed({{10{cfg.display_offset[12]}}, cfg.display_offset, 20'd0});
      s2_neg  <= s1_neg;
      s2_on   <= s1_on;
      s2_fe   <= s1_fe;

      // divide by 2^24-1: fold high part into low part twice
      s3_q0   <= num[55:24];
      s3_r    <= 33'(num[23:0]) + 33'(num[55:24]);
      s3_base <= s2_base;
      s3_neg  <= s2_neg;
      s3_on   <= s2_on;
      s3_fe   <= s2_fe;

      s4_q    <= s3_q0 + 32'(q1) + 32'(r1 >= 25'(UNIT_MAX));
      s4_base <= s3_base;
      s4_neg  <= s3_neg;
      s4_on   <= s3_on;
      s4_fe   <= s3_fe;

      s5_level <= cfg.white_hot ? clamped : (GRAY_MAX_Q24 - clamped);
      s5_fe    <= s4_fe;

      gray.gray_value    <= rounded[31:24];
      gray.frame_end_out <= s5_fe;
    end
  end

endmodule

@@ src/rgb_to_ir_gray_postprocess.sv @@
// Top level of the RGB to gray post-processing block: configuration
// registers plus front end, queue and back end. Depends on rtig_pkg.
//
// Usage:
//  - pixel channel: one RGB word per accepted cycle (pixel_valid high,
//    pixel_stall low). Luma is formed and the xorshift32 noise generator
//    steps on acceptance, only while noise is enabled with nonzero sigma.
//  - gray channel: one gray word per pixel, in order; the byte is meant to
//    be replicated onto R, G and B. The frame-end flag rides along.
//  - cfg channel: cfg_ready is always high; cfg_index selects gain, offset,
//    noise enable, sigma, white-hot (0..4); other indexes are dropped.
//    Write only while no pixel is in flight.
//  - Path: from pixel acceptance through a queue slot, back stages s1 to s5 and the gray output register to gray_valid.
//  - Throughput: one pixel per cycle while pixel_stall is low; the generator
//    update is combinational and the back end is a six-stage pipeline.
//  - gray_stall holds the whole back pipeline; the 4-entry queue keeps
//    taking pixels until it fills, then pixel_stall rises.
//  - Reset (rst, synchronous) empties the queue and pipeline, reseeds the
//    generator to 0x6D2B79F5 and restores register defaults.
module rgb_to_ir_gray_postprocess
  import rtig_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  gray_valid,
  input  logic                  gray_stall,
  output gray_t                 gray,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_avail;
  entry_t q_head;

  assign cfg_ready = 1'b1;

  // register file; extra data bits are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_gain   <= 16'd256;
      cfg.display_offset <= '0;
      cfg.noise_enable   <= 1'b0;
      cfg.noise_sigma    <= '0;
      cfg.white_hot      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN:      cfg.display_gain   <= cfg_data;
        REG_OFFSET:    cfg.display_offset <= cfg_data[12:0];
        REG_NOISE_EN:  cfg.noise_enable   <= cfg_data[0];
        REG_SIGMA:     cfg.noise_sigma    <= cfg_data;
        REG_WHITE_HOT: cfg.white_hot      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rtig_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  rtig_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  rtig_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_avail    (q_avail),
    .q_pop      (q_pop),
    .q_head     (q_head),
    .gray_valid (gray_valid),
    .gray_stall (gray_stall),
    .gray       (gray)
  );

endmodule
